>>> src/wasm_instruction_decoder_assert.svh
// Assertion macros for the instruction decoder checker.
`ifndef WASM_INSTRUCTION_DECODER_ASSERT_SVH
`define WASM_INSTRUCTION_DECODER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define WID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define WID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> src/wid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wid_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 216;
	localparam int ERR_W      = 3;

	localparam int MAX_NESTING = 255;
	localparam int DEPTH_CAP   = (MAX_NESTING < 255) ? MAX_NESTING : 255;
	localparam logic [7:0] DEPTH_LIMIT = 8'(DEPTH_CAP);

	localparam logic [7:0] OP_UNREACHABLE = 8'h00;
	localparam logic [7:0] OP_NOP         = 8'h01;
	localparam logic [7:0] OP_IF          = 8'h04;
	localparam logic [7:0] OP_ELSE        = 8'h05;
	localparam logic [7:0] OP_END         = 8'h0B;
	localparam logic [7:0] OP_RETURN      = 8'h0F;
	localparam logic [7:0] OP_CALL        = 8'h10;
	localparam logic [7:0] OP_CALL_IND    = 8'h11;
	localparam logic [7:0] OP_RET_CALL    = 8'h12;
	localparam logic [7:0] OP_RET_CALL_IND = 8'h13;
	localparam logic [7:0] OP_DROP        = 8'h1A;
	localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
	localparam logic [7:0] OP_LOCAL_SET   = 8'h21;
	localparam logic [7:0] OP_MEM_FIRST   = 8'h28;
	localparam logic [7:0] OP_MEM_LAST    = 8'h3E;
	localparam logic [7:0] OP_MEM_SIZE    = 8'h3F;
	localparam logic [7:0] OP_MEM_GROW    = 8'h40;
	localparam logic [7:0] OP_I32_CONST   = 8'h41;
	localparam logic [7:0] OP_I64_CONST   = 8'h42;
	localparam logic [7:0] OP_F32_CONST   = 8'h43;
	localparam logic [7:0] OP_F64_CONST   = 8'h44;
	localparam logic [7:0] OP_NUM_FIRST   = 8'h45;
	localparam logic [7:0] OP_NUM_LAST    = 8'hC4;

	localparam logic [63:0] MEMARG_INDEX_MIN = 64'd64;
	localparam logic [3:0]  F32_BYTES   = 4'd4;
	localparam logic [3:0]  F64_BYTES   = 4'd8;
	localparam logic [3:0]  I32_LEB_MAX = 4'd5;
	localparam logic [3:0]  I64_LEB_MAX = 4'd10;
	localparam logic [6:0]  LEB_STEP    = 7'd7;
	localparam logic [6:0]  ACC_BITS    = 7'd64;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_I32  = 3'd1,
		KIND_I64  = 3'd2,
		KIND_F32  = 3'd3,
		KIND_F64  = 3'd4,
		KIND_MEMN = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_UNSUPPORTED = 3'd1,
		ERR_TRUNCATED   = 3'd2,
		ERR_OVERLONG    = 3'd3,
		ERR_NESTING     = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		PH_OPCODE = 2'b01,
		PH_IMM    = 2'b10
	} phase_t;

	typedef struct packed {
		logic          supported;
		kind_t [2:0]   kinds;
	} class_t;

	typedef struct packed {
		logic [7:0]  nesting_depth;
		logic [63:0] imm_third;
		logic [63:0] imm_second;
		logic [63:0] imm_first;
		logic [1:0]  imm_count;
		logic [7:0]  opcode;
	} result_data_t;

	localparam int RES_DATA_W = $bits(result_data_t);
	localparam int PAD_W      = OUT_DATA_W - RES_DATA_W;

	typedef struct packed {
		logic         expr_end;
		err_t         error_code;
		result_data_t data;
	} result_t;

	function automatic class_t classify(input logic [7:0] op);
		class_t c;
		c.supported = 1'b1;
		c.kinds     = '{KIND_NONE, KIND_NONE, KIND_NONE};
		if (op == OP_END) begin
			c.supported = 1'b1;
		end else if (op >= OP_MEM_FIRST && op <= OP_MEM_LAST) begin
			c.kinds[0] = KIND_MEMN;
			c.kinds[1] = KIND_I64;
		end else if (op >= OP_NUM_FIRST && op <= OP_NUM_LAST) begin
			c.supported = 1'b1;
		end else begin
			case (op)
				OP_UNREACHABLE, OP_NOP, OP_ELSE, OP_RETURN, OP_DROP: begin
					c.supported = 1'b1;
				end
				OP_I32_CONST, OP_MEM_SIZE, OP_MEM_GROW, OP_CALL, OP_RET_CALL,
				OP_LOCAL_SET, OP_LOCAL_GET, OP_IF: begin
					c.kinds[0] = KIND_I32;
				end
				OP_I64_CONST: begin
					c.kinds[0] = KIND_I64;
				end
				OP_CALL_IND, OP_RET_CALL_IND: begin
					c.kinds[0] = KIND_I32;
					c.kinds[1] = KIND_I32;
				end
				OP_F32_CONST: begin
					c.kinds[0] = KIND_F32;
				end
				OP_F64_CONST: begin
					c.kinds[0] = KIND_F64;
				end
				default: begin
					c.supported = 1'b0;
				end
			endcase
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/wasm_instruction_decoder.sv
// Each byte is registered on input; its result is then registered in the output queue for the master side.
// The decoder takes one byte per cycle while the output queue is not full; its state updates once per byte.
// A two-entry output queue lets bytes keep flowing while one result waits.
// Reset (arst_n low, asynchronous) clears the decoder state and all valid flags.
// A byte with tlast set returns the decoder state to its reset values.
`timescale 1ns / 1ps
`default_nettype none

module wasm_instruction_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wid_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] opcode, [9:8] imm_count, [73:10] imm_first, [137:74] imm_second,
	// [201:138] imm_third, [209:202] nesting_depth, [215:210] zero
	output logic [wid_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [wid_pkg::ERR_W-1:0]      m_tuser,  // [2:0] error_code
	output logic                           m_tlast
);
	import wid_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	phase_t              phase_q;
	logic [7:0]          opcode_q;
	kind_t [2:0]         kinds_q;
	logic [1:0]          slot_q;
	logic [63:0]         acc_q;
	logic [5:0]          shift_q;
	logic [3:0]          nbytes_q;
	logic [2:0][63:0]    store_q;
	logic [7:0]          depth_q;

	phase_t              phase_n;
	logic [7:0]          opcode_n;
	kind_t [2:0]         kinds_n;
	logic [1:0]          slot_n;
	logic [63:0]         acc_n;
	logic [5:0]          shift_n;
	logic [3:0]          nbytes_n;
	logic [2:0][63:0]    store_n;
	logic [7:0]          depth_n;

	logic                out_valid_q;
	result_t             out_q;
	logic                sk_valid_q;
	result_t             sk_q;

	logic                fire;
	logic                res_valid;
	result_t             res;

	class_t              cls;
	kind_t               kind;
	kind_t               next_kind;
	logic                is_float;
	logic [3:0]          nb_inc;
	logic [63:0]         acc_f;
	logic [63:0]         acc_l0;
	logic [63:0]         acc_l1;
	logic [63:0]         acc_l;
	logic [6:0]          fill_pos;
	logic                f_done;
	logic                cont;
	logic                overlong;
	logic                done;
	logic [63:0]         field_val;

	logic                fin;
	err_t                fin_err;
	err_t                err;
	logic [7:0]          fin_opcode;
	logic [1:0]          fin_slot;
	logic [2:0][63:0]    fin_store;
	logic                closes;
	logic [7:0]          depth_r;

	assign fire     = valid_s1 && !sk_valid_q;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	assign cls = classify(byte_s1);

	always_comb begin
		case (slot_q)
			2'd0: kind = kinds_q[0];
			2'd1: kind = kinds_q[1];
			2'd2: kind = kinds_q[2];
			default: kind = KIND_NONE;
		endcase
	end

	assign is_float = (kind == KIND_F32) || (kind == KIND_F64);
	assign nb_inc   = nbytes_q + 4'd1;
	assign cont     = byte_s1[7];

	assign acc_f  = acc_q | ({56'd0, byte_s1} << {nbytes_q[2:0], 3'b000});
	assign f_done = nb_inc >= ((kind == KIND_F32) ? F32_BYTES : F64_BYTES);

	assign acc_l0   = acc_q | ({57'd0, byte_s1[6:0]} << shift_q);
	assign fill_pos = {1'b0, shift_q} + LEB_STEP;
	assign acc_l1   = (byte_s1[6] && !cont && fill_pos < ACC_BITS) ?
		(acc_l0 | ({64{1'b1}} << fill_pos[5:0])) : acc_l0;
	assign acc_l    = (kind == KIND_I64) ? acc_l1 : {{32{acc_l1[31]}}, acc_l1[31:0]};
	assign overlong = cont && (nb_inc >= ((kind == KIND_I64) ? I64_LEB_MAX : I32_LEB_MAX));

	assign done      = (kind == KIND_NONE) || (is_float ? f_done : !cont);
	assign field_val = (kind == KIND_NONE) ? acc_q : (is_float ? acc_f : acc_l);

	always_comb begin
		phase_n    = phase_q;
		opcode_n   = opcode_q;
		kinds_n    = kinds_q;
		slot_n     = slot_q;
		acc_n      = acc_q;
		shift_n    = shift_q;
		nbytes_n   = nbytes_q;
		store_n    = store_q;
		depth_n    = depth_q;
		fin        = 1'b0;
		fin_err    = ERR_OK;
		fin_opcode = opcode_q;
		fin_slot   = slot_q;
		fin_store  = store_q;
		next_kind  = KIND_NONE;
		err        = ERR_OK;
		closes     = 1'b0;
		depth_r    = depth_q;

		if (phase_q == PH_OPCODE) begin
			opcode_n   = byte_s1;
			kinds_n    = cls.kinds;
			slot_n     = 2'd0;
			store_n    = '0;
			acc_n      = '0;
			shift_n    = '0;
			nbytes_n   = '0;
			fin_opcode = byte_s1;
			fin_slot   = 2'd0;
			fin_store  = '0;
			if (!cls.supported) begin
				fin     = 1'b1;
				fin_err = ERR_UNSUPPORTED;
			end else if (cls.kinds[0] == KIND_NONE) begin
				fin = 1'b1;
			end else begin
				phase_n = PH_IMM;
			end
		end else if (kind != KIND_NONE && !is_float && overlong) begin
			fin     = 1'b1;
			fin_err = ERR_OVERLONG;
		end else if (done) begin
			case (slot_q)
				2'd0: store_n[0] = field_val;
				2'd1: store_n[1] = field_val;
				2'd2: store_n[2] = field_val;
				default: store_n = store_q;
			endcase
			if (kind == KIND_MEMN && !field_val[63] && field_val >= MEMARG_INDEX_MIN) begin
				kinds_n[1] = KIND_I32;
				kinds_n[2] = KIND_I64;
			end
			slot_n   = slot_q + 2'd1;
			acc_n    = '0;
			shift_n  = '0;
			nbytes_n = '0;
			case (slot_n)
				2'd1: next_kind = kinds_n[1];
				2'd2: next_kind = kinds_n[2];
				default: next_kind = KIND_NONE;
			endcase
			fin_slot  = slot_n;
			fin_store = store_n;
			if (next_kind == KIND_NONE) begin
				fin = 1'b1;
			end
		end else begin
			acc_n    = field_val;
			nbytes_n = nb_inc;
			shift_n  = is_float ? shift_q : (shift_q + 6'(LEB_STEP));
		end

		err = fin ? fin_err : ERR_TRUNCATED;
		if (fin && err == ERR_OK) begin
			if (fin_opcode == OP_END) begin
				if (depth_q == 8'd0) begin
					closes = 1'b1;
				end else begin
					depth_r = depth_q - 8'd1;
				end
			end else if (fin_opcode == OP_IF) begin
				if (depth_q >= DEPTH_LIMIT) begin
					err = ERR_NESTING;
				end else begin
					depth_r = depth_q + 8'd1;
				end
			end
			if (err == ERR_OK && last_s1 && !closes) begin
				err = ERR_TRUNCATED;
			end
		end

		if (fin) begin
			phase_n  = PH_OPCODE;
			slot_n   = 2'd0;
			acc_n    = '0;
			shift_n  = '0;
			nbytes_n = '0;
			depth_n  = depth_r;
		end

		if (last_s1) begin
			phase_n  = PH_OPCODE;
			opcode_n = '0;
			kinds_n  = '{KIND_NONE, KIND_NONE, KIND_NONE};
			slot_n   = 2'd0;
			acc_n    = '0;
			shift_n  = '0;
			nbytes_n = '0;
			store_n  = '0;
			depth_n  = '0;
		end
	end

	assign res_valid = fire && (fin || last_s1);

	always_comb begin
		res.expr_end           = closes;
		res.error_code         = err;
		res.data.opcode        = fin_opcode;
		res.data.imm_count     = fin_slot;
		res.data.imm_first     = (fin_slot > 2'd0) ? fin_store[0] : '0;
		res.data.imm_second    = (fin_slot > 2'd1) ? fin_store[1] : '0;
		res.data.imm_third     = (fin_slot > 2'd2) ? fin_store[2] : '0;
		res.data.nesting_depth = depth_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			opcode_q <= '0;
			kinds_q  <= '{KIND_NONE, KIND_NONE, KIND_NONE};
			slot_q   <= '0;
			acc_q    <= '0;
			shift_q  <= '0;
			nbytes_q <= '0;
			store_q  <= '0;
			depth_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			kinds_q  <= kinds_n;
			slot_q   <= slot_n;
			acc_q    <= acc_n;
			shift_q  <= shift_n;
			nbytes_q <= nbytes_n;
			store_q  <= store_n;
			depth_q  <= depth_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (out_valid_q && m_tready) begin
			if (sk_valid_q) begin
				sk_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			if (out_valid_q) begin
				sk_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && m_tready) begin
			if (sk_valid_q) begin
				out_q <= sk_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			if (out_valid_q) begin
				sk_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), out_q.data};
	assign m_tuser  = out_q.error_code;
	assign m_tlast  = out_q.expr_end;

endmodule

`default_nettype wire

>>> src/wid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "wasm_instruction_decoder_assert.svh"

module wid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wid_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [wid_pkg::ERR_W-1:0]      m_tuser,
	input logic                           m_tlast
);
	import wid_pkg::*;

	result_data_t view;

	assign view = m_tdata[RES_DATA_W-1:0];

	`WID_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
	`WID_ASSERT_NOW(a_close_is_end, m_tvalid && m_tlast, m_tuser == ERR_OK && view.opcode == OP_END && view.nesting_depth == 8'd0 && view.imm_count == 2'd0, "expression close malformed")
	`WID_ASSERT_NOW(a_unsup_no_imm, m_tvalid && m_tuser == ERR_UNSUPPORTED, view.imm_count == 2'd0 && !m_tlast, "unsupported opcode carries immediates")
	`WID_ASSERT_NOW(a_three_memarg, m_tvalid && view.imm_count == 2'd3, view.opcode >= OP_MEM_FIRST && view.opcode <= OP_MEM_LAST, "three immediates outside memarg")

endmodule

bind wasm_instruction_decoder wid_checker u_wid_checker (.*);

`default_nettype wire

>>> test/wasm_decode_checker.sv
`timescale 1ns / 1ps

module wasm_decode_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [wid_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [wid_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [wid_pkg::ERR_W-1:0]      m_tuser,
	input  logic                           m_tlast,
	output int                             mismatches,
	output int                             outstanding
);
	import wid_pkg::*;

	localparam int FIELD_MORE     = 0;
	localparam int FIELD_DONE     = 1;
	localparam int FIELD_OVERLONG = 2;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [1:0]  count;
		logic [63:0] imm0;
		logic [63:0] imm1;
		logic [63:0] imm2;
		logic [7:0]  depth;
		logic        closes;
		logic [2:0]  err;
	} decoded_t;

	decoded_t pending_instrs[$];

	logic        in_imm;
	logic [7:0]  cur_op;
	kind_t       kinds [3];
	logic [1:0]  slot;
	logic [63:0] acc;
	logic [6:0]  shamt;
	logic [3:0]  nbytes;
	logic [63:0] stored [3];
	logic [7:0]  depth;

	task automatic clear_field();
		acc = '0;
		shamt = '0;
		nbytes = '0;
	endtask

	task automatic clear_decode();
		in_imm = 1'b0;
		cur_op = '0;
		slot = '0;
		depth = '0;
		for (int i = 0; i < 3; i++) begin
			kinds[i] = KIND_NONE;
			stored[i] = '0;
		end
		clear_field();
	endtask

	task automatic load_kinds(input logic [7:0] op, output logic ok);
		ok = 1'b1;
		kinds[0] = KIND_NONE;
		kinds[1] = KIND_NONE;
		kinds[2] = KIND_NONE;
		if (op >= OP_MEM_FIRST && op <= OP_MEM_LAST) begin
			kinds[0] = KIND_MEMN;
			kinds[1] = KIND_I64;
		end else if (!(op == OP_END || (op >= OP_NUM_FIRST && op <= OP_NUM_LAST))) begin
			case (op)
				OP_UNREACHABLE, OP_NOP, OP_ELSE, OP_RETURN, OP_DROP: ;
				OP_I32_CONST, OP_MEM_SIZE, OP_MEM_GROW, OP_CALL, OP_RET_CALL,
				OP_LOCAL_GET, OP_LOCAL_SET, OP_IF: kinds[0] = KIND_I32;
				OP_I64_CONST: kinds[0] = KIND_I64;
				OP_CALL_IND, OP_RET_CALL_IND: begin
					kinds[0] = KIND_I32;
					kinds[1] = KIND_I32;
				end
				OP_F32_CONST: kinds[0] = KIND_F32;
				OP_F64_CONST: kinds[0] = KIND_F64;
				default: ok = 1'b0;
			endcase
		end
	endtask

	task automatic take_field_byte(input kind_t kind, input logic [7:0] b, output int status);
		if (kind == KIND_F32 || kind == KIND_F64) begin
			acc = acc | (64'(b) << (nbytes * 8));
			nbytes = nbytes + 4'd1;
			status = (nbytes >= ((kind == KIND_F32) ? F32_BYTES : F64_BYTES)) ?
				FIELD_DONE : FIELD_MORE;
		end else begin
			if (shamt < ACC_BITS)
				acc = acc | (64'(b[6:0]) << shamt);
			nbytes = nbytes + 4'd1;
			if (b[7]) begin
				if (nbytes >= ((kind == KIND_I64) ? I64_LEB_MAX : I32_LEB_MAX)) begin
					status = FIELD_OVERLONG;
				end else begin
					shamt = shamt + LEB_STEP;
					status = FIELD_MORE;
				end
			end else begin
				if (int'(shamt) + int'(LEB_STEP) < int'(ACC_BITS) && b[6])
					acc = acc | (~64'd0 << (shamt + LEB_STEP));
				if (kind != KIND_I64)
					acc = {{32{acc[31]}}, acc[31:0]};
				status = FIELD_DONE;
			end
		end
	endtask

	task automatic close_instr(input logic [2:0] err_in, input logic lst);
		logic [2:0] err;
		logic       closes;
		decoded_t   r;
		err = err_in;
		closes = 1'b0;
		if (err == ERR_OK) begin
			if (cur_op == OP_END) begin
				if (depth == 0)
					closes = 1'b1;
				else
					depth = depth - 8'd1;
			end else if (cur_op == OP_IF) begin
				if (depth >= DEPTH_LIMIT)
					err = ERR_NESTING;
				else
					depth = depth + 8'd1;
			end
			if (err == ERR_OK && lst && !closes)
				err = ERR_TRUNCATED;
		end
		r.opcode = cur_op;
		r.count = slot;
		r.imm0 = (slot > 0) ? stored[0] : '0;
		r.imm1 = (slot > 1) ? stored[1] : '0;
		r.imm2 = (slot > 2) ? stored[2] : '0;
		r.depth = depth;
		r.closes = closes;
		r.err = err;
		pending_instrs.insert(pending_instrs.size(), r);
		in_imm = 1'b0;
		slot = '0;
		clear_field();
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic lst);
		logic       ok;
		logic       produced;
		logic [1:0] s;
		kind_t      k;
		int         status;
		produced = 1'b0;
		if (!in_imm) begin
			cur_op = b;
			slot = '0;
			for (int i = 0; i < 3; i++)
				stored[i] = '0;
			clear_field();
			load_kinds(b, ok);
			if (!ok) begin
				close_instr(ERR_UNSUPPORTED, lst);
				produced = 1'b1;
			end else if (kinds[0] == KIND_NONE) begin
				close_instr(ERR_OK, lst);
				produced = 1'b1;
			end else begin
				in_imm = 1'b1;
			end
		end else begin
			s = slot;
			k = KIND_NONE;
			if (s < 3)
				k = kinds[s];
			if (k == KIND_NONE)
				status = FIELD_DONE;
			else
				take_field_byte(k, b, status);
			if (status == FIELD_OVERLONG) begin
				close_instr(ERR_OVERLONG, lst);
				produced = 1'b1;
			end else if (status == FIELD_DONE) begin
				if (s < 3)
					stored[s] = acc;
				if (k == KIND_MEMN && $signed(acc) >= $signed(MEMARG_INDEX_MIN)) begin
					kinds[1] = KIND_I32;
					kinds[2] = KIND_I64;
				end
				slot = s + 2'd1;
				clear_field();
				if (slot == 3 || kinds[slot] == KIND_NONE) begin
					close_instr(ERR_OK, lst);
					produced = 1'b1;
				end
			end
		end
		if (lst) begin
			if (!produced)
				close_instr(ERR_TRUNCATED, lst);
			clear_decode();
		end
	endtask

	task automatic compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t     want;
		result_data_t got;
		if (!arst_n) begin
			clear_decode();
			pending_instrs.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_instrs.size() == 0) begin
					$display("%0t: result expected none, got opcode %h", $time, m_tdata[7:0]);
					mismatches++;
				end else begin
					want = pending_instrs.pop_front();
					got = m_tdata[RES_DATA_W-1:0];
					compare_field("opcode", 64'(want.opcode), 64'(got.opcode));
					compare_field("imm_count", 64'(want.count), 64'(got.imm_count));
					compare_field("imm_first", want.imm0, got.imm_first);
					compare_field("imm_second", want.imm1, got.imm_second);
					compare_field("imm_third", want.imm2, got.imm_third);
					compare_field("nesting_depth", 64'(want.depth),
						64'(got.nesting_depth));
					compare_field("padding", '0, 64'(m_tdata[OUT_DATA_W-1:RES_DATA_W]));
					compare_field("error_code", 64'(want.err), 64'(m_tuser));
					compare_field("expr_end", 64'(want.closes), 64'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			outstanding = pending_instrs.size();
		end
	end

endmodule

>>> test/wasm_instruction_decoder_test.sv
`timescale 1ns / 1ps

module wasm_instruction_decoder_test;
	import wid_pkg::*;

	localparam int BYTE_TARGET  = 1650;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 12;

	localparam logic [7:0] OP_BLOCK        = 8'h02;
	localparam logic [7:0] OP_LOOP         = 8'h03;
	localparam logic [7:0] BLOCKTYPE_EMPTY = 8'h40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [ERR_W-1:0]      m_tuser;
	logic                  m_tlast;

	int mismatches;
	int outstanding;

	logic [7:0] code_bytes[$];
	logic       code_last[$];
	int         directed_len;
	int         gen_depth = 0;
	logic       deep_done = 1'b0;
	logic       tx_burst = 1'b0;
	logic       rx_burst = 1'b0;
	logic       rx_took = 1'b0;
	int         rx_hold = 0;
	int         idle_cycles = 0;

	always #2 clk = ~clk;

	wasm_instruction_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	wasm_decode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	task automatic emit_byte(input logic [7:0] b);
		code_bytes.insert(code_bytes.size(), b);
		code_last.insert(code_last.size(), 1'b0);
	endtask

	task automatic mark_last();
		code_last[code_last.size()-1] = 1'b1;
	endtask

	task automatic emit_raw(input logic [3:0] count);
		repeat (count) emit_byte(8'($urandom));
	endtask

	task automatic emit_leb(input logic [3:0] max_len, input logic overlong);
		int n;
		if (overlong)
			n = int'(max_len);
		else if ($urandom_range(0, 1) != 0)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(1, max_len);
		for (int i = 1; i < n; i++)
			emit_byte(8'h80 | 8'($urandom_range(0, 127)));
		if (overlong)
			emit_byte(8'h80 | 8'($urandom_range(0, 127)));
		else
			emit_byte(8'($urandom_range(0, 127)));
	endtask

	task automatic emit_memarg(input logic overlong);
		int mode;
		emit_byte(8'($urandom_range(OP_MEM_FIRST, OP_MEM_LAST)));
		mode = $urandom_range(0, 3);
		if (mode == 0) begin
			emit_byte(8'hC0);
			emit_byte(8'h00);
		end else if (mode == 1) begin
			emit_byte(8'h80 | 8'($urandom_range(0, 127)));
			repeat ($urandom_range(0, 2)) emit_byte(8'h80 | 8'($urandom_range(0, 127)));
			emit_byte(8'($urandom_range(1, 63)));
		end else begin
			emit_byte(8'($urandom_range(0, 127)));
		end
		if (mode < 2)
			emit_leb(I32_LEB_MAX, 1'b0);
		emit_leb(I64_LEB_MAX, overlong);
	endtask

	function automatic logic [7:0] pick_plain_op();
		case ($urandom_range(0, 7))
			0: return OP_UNREACHABLE;
			1: return OP_NOP;
			2: return OP_ELSE;
			3: return OP_RETURN;
			4: return OP_DROP;
			default: return 8'($urandom_range(OP_NUM_FIRST, OP_NUM_LAST));
		endcase
	endfunction

	function automatic logic [7:0] pick_i32_op();
		case ($urandom_range(0, 6))
			0: return OP_I32_CONST;
			1: return OP_MEM_SIZE;
			2: return OP_MEM_GROW;
			3: return OP_CALL;
			4: return OP_RET_CALL;
			5: return OP_LOCAL_GET;
			default: return OP_LOCAL_SET;
		endcase
	endfunction

	function automatic logic [7:0] pick_unsupported();
		case ($urandom_range(0, 3))
			0: return OP_BLOCK;
			1: return OP_LOOP;
			2: return 8'($urandom_range(OP_ELSE + 1, OP_END - 1));
			default: return 8'($urandom_range(OP_NUM_LAST + 1, 255));
		endcase
	endfunction

	task automatic emit_instr();
		int pick;
		int start;
		int cut;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			emit_byte(pick_plain_op());
		end else if (pick < 22) begin
			emit_byte(OP_IF);
			emit_leb(I32_LEB_MAX, 1'b0);
			gen_depth++;
		end else if (pick < 32) begin
			emit_byte(OP_END);
			if (gen_depth > 0)
				gen_depth--;
		end else if (pick < 47) begin
			emit_byte(pick_i32_op());
			emit_leb(I32_LEB_MAX, 1'b0);
		end else if (pick < 54) begin
			emit_byte(OP_I64_CONST);
			emit_leb(I64_LEB_MAX, 1'b0);
		end else if (pick < 59) begin
			emit_byte(($urandom_range(0, 1) != 0) ? OP_CALL_IND : OP_RET_CALL_IND);
			emit_leb(I32_LEB_MAX, 1'b0);
			emit_leb(I32_LEB_MAX, 1'b0);
		end else if (pick < 64) begin
			emit_byte(OP_F32_CONST);
			emit_raw(F32_BYTES);
		end else if (pick < 69) begin
			emit_byte(OP_F64_CONST);
			emit_raw(F64_BYTES);
		end else if (pick < 81) begin
			emit_memarg(1'b0);
		end else if (pick < 86) begin
			emit_byte(pick_unsupported());
		end else if (pick < 89) begin
			case ($urandom_range(0, 2))
				0: begin
					emit_byte(pick_i32_op());
					emit_leb(I32_LEB_MAX, 1'b1);
				end
				1: begin
					emit_byte(OP_I64_CONST);
					emit_leb(I64_LEB_MAX, 1'b1);
				end
				default: emit_memarg(1'b1);
			endcase
		end else if (pick < 93) begin
			repeat (gen_depth) emit_byte(OP_END);
			emit_byte(OP_END);
			mark_last();
			gen_depth = 0;
		end else if (pick < 96) begin
			start = code_bytes.size();
			if ($urandom_range(0, 1) != 0) begin
				emit_memarg(1'b0);
			end else begin
				emit_byte(OP_F64_CONST);
				emit_raw(F64_BYTES);
			end
			cut = $urandom_range(start, code_bytes.size() - 1);
			while (code_bytes.size() > cut + 1) begin
				void'(code_bytes.pop_back());
				void'(code_last.pop_back());
			end
			mark_last();
			gen_depth = 0;
		end else begin
			emit_byte(8'($urandom));
		end
	endtask

	task automatic emit_deep_nesting();
		emit_byte(OP_NOP);
		mark_last();
		repeat (DEPTH_CAP + 1) begin
			emit_byte(OP_IF);
			emit_byte(BLOCKTYPE_EMPTY);
		end
		emit_byte(OP_END);
		mark_last();
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = lst;
		// hold the request until it is taken
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) rx_took <= m_tvalid && m_tready;

	always @(negedge clk) begin : rx_side
		int gap;
		if ($urandom_range(0, 63) == 0)
			rx_burst <= !rx_burst;
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_took && !rx_burst) begin
			gap = $urandom_range(0, 7);
			m_tready <= (gap == 0);
			rx_hold <= (gap == 0) ? 0 : gap - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		emit_byte(OP_IF); emit_byte(BLOCKTYPE_EMPTY);
		emit_byte(OP_ELSE);
		emit_byte(OP_END);
		emit_byte(OP_BLOCK);
		emit_byte(OP_LOOP);
		emit_byte(8'hFF);
		emit_byte(OP_I32_CONST); repeat (5) emit_byte(8'h80);
		emit_byte(OP_F32_CONST);
		emit_byte(8'h00); emit_byte(8'h00); emit_byte(8'h80); emit_byte(8'h7F);
		emit_byte(OP_MEM_FIRST);
		emit_byte(8'hC0); emit_byte(8'h00); emit_byte(8'h05); emit_byte(8'h7F);
		emit_byte(OP_END);
		emit_byte(OP_I64_CONST); emit_byte(8'hFF);
		mark_last();
		directed_len = code_bytes.size();

		while (code_bytes.size() < BYTE_TARGET) begin
			if (!deep_done && code_bytes.size() >= BYTE_TARGET / 2) begin
				emit_deep_nesting();
				deep_done = 1'b1;
			end
			emit_instr();
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < code_bytes.size(); i++) begin
			// drain every pending result before going on
			if (i == directed_len || $urandom_range(0, 299) == 0) begin
				s_tvalid = 1'b0;
				while (outstanding != 0) @(negedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				tx_burst = !tx_burst;
			send_byte(code_bytes[i], code_last[i]);
		end
		s_tvalid = 1'b0;
		s_tlast = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/wid_pkg.sv
src/wasm_instruction_decoder.sv
src/wid_checker.sv
test/wasm_decode_checker.sv
test/wasm_instruction_decoder_test.sv
